### rtl/mex_pkg.sv
package mex_pkg;

    // Fixed widths of the exponent, base and result fields
    localparam int FIELD_W = 24;

    localparam int DEF_MODULUS_BITS = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

endpackage

### rtl/mex_modmul.sv
module mex_modmul #(
    parameter int MODULUS_BITS = mex_pkg::DEF_MODULUS_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [((MODULUS_BITS > mex_pkg::FIELD_W) ? MODULUS_BITS : mex_pkg::FIELD_W)-1:0] i_a,
    input  logic [MODULUS_BITS-1:0] i_b,
    input  logic [MODULUS_BITS-1:0] i_m,
    output logic                    o_done,
    output logic [MODULUS_BITS-1:0] o_p
);
    import mex_pkg::*;

    localparam int MW = MODULUS_BITS;
    localparam int AW = (MW > FIELD_W) ? MW : FIELD_W;
    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] r_a;
    logic [MW-1:0] r_b;
    logic [MW-1:0] r_m;
    logic [MW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [MW+1:0] w_t0;
    logic [MW+1:0] w_t1;
    logic [MW+1:0] w_t2;
    logic [MW+1:0] w_mx;

    // One interleaved step: acc = 2*acc + bit*b, then bring back below m
    always_comb begin
        w_mx = {2'b00, r_m};
        w_t0 = {1'b0, r_acc, 1'b0} + (r_a[AW-1] ? {2'b00, r_b} : '0);
        w_t1 = (w_t0 >= w_mx) ? (w_t0 - w_mx) : w_t0;
        w_t2 = (w_t1 >= w_mx) ? (w_t1 - w_mx) : w_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[AW-2:0], 1'b0};
            r_acc <= w_t2[MW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

### rtl/mex_seq.sv
module mex_seq #(
    parameter int MODULUS_BITS = mex_pkg::DEF_MODULUS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mex_pkg::FIELD_W-1:0]   i_base,
    input  logic [mex_pkg::FIELD_W-1:0]   i_exponent,
    input  logic [MODULUS_BITS-1:0]       i_modulus,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mex_pkg::FIELD_W-1:0]   o_power_mod,
    output logic                          o_mul_start,
    output logic [((MODULUS_BITS > mex_pkg::FIELD_W) ? MODULUS_BITS : mex_pkg::FIELD_W)-1:0] o_mul_a,
    output logic [MODULUS_BITS-1:0]       o_mul_b,
    output logic [MODULUS_BITS-1:0]       o_mul_m,
    input  logic                          i_mul_done,
    input  logic [MODULUS_BITS-1:0]       i_mul_p
);
    import mex_pkg::*;

    localparam int MW = MODULUS_BITS;
    localparam int AW = (MW > FIELD_W) ? MW : FIELD_W;

    t_state             r_state, n_state;
    logic               r_go,    n_go;
    logic [FIELD_W-1:0] r_e,     n_e;
    logic [FIELD_W-1:0] r_base,  n_base;
    logic [MW-1:0]      r_m,     n_m;
    logic [MW-1:0]      r_acc,   n_acc;
    logic [MW-1:0]      r_sq,    n_sq;

    logic w_accept;
    assign w_accept = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_e     = r_e;
        n_base  = r_base;
        n_m     = r_m;
        n_acc   = r_acc;
        n_sq    = r_sq;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_e    = i_exponent;
                    n_base = i_base;
                    n_m    = i_modulus;
                    if (i_exponent == '0) begin
                        n_acc   = MW'(1);
                        n_state = S_DONE;
                    end else if (i_modulus == '0) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED;
                        n_go    = 1'b1;
                    end
                end
            end
            S_RED: begin
                if (i_mul_done) begin
                    n_sq    = i_mul_p;
                    n_acc   = (r_m == MW'(1)) ? '0 : MW'(1);
                    n_state = r_e[0] ? S_MUL : S_SQR;
                    n_go    = 1'b1;
                end
            end
            S_MUL: begin
                if (i_mul_done) begin
                    n_acc = i_mul_p;
                    // skip the last square once no exponent bits remain
                    if (r_e[FIELD_W-1:1] == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQR;
                        n_go    = 1'b1;
                    end
                end
            end
            S_SQR: begin
                if (i_mul_done) begin
                    n_sq    = i_mul_p;
                    n_e     = {1'b0, r_e[FIELD_W-1:1]};
                    n_state = r_e[1] ? S_MUL : S_SQR;
                    n_go    = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
        o_mul_m = r_m;
        case (r_state)
            S_RED: begin
                o_mul_a = AW'(r_base);
                o_mul_b = MW'(1);
            end
            S_MUL: begin
                o_mul_a = AW'(r_acc);
                o_mul_b = r_sq;
            end
            default: begin
                o_mul_a = AW'(r_sq);
                o_mul_b = r_sq;
            end
        endcase
    end

    assign o_mul_start = r_go;
    assign o_power_mod = FIELD_W'(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_base <= n_base;
        r_m    <= n_m;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
    end

endmodule

### rtl/modular_exponentiation.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_base [23:0]
// result    out        o_valid / i_stall  o_power_mod [23:0]
// config    in         i_cfg_we           i_cfg_idx, i_cfg_wdata [23:0]
//
// One base at a time. Each modular multiply runs on the shared interleaved
// multiply-reduce unit of width AW = max(MODULUS_BITS, 24); an item takes
// (1 + popcount(e) + floor(log2 e)) multiplies, and an exponent or modulus
// of zero takes none. Reset is synchronous, active low, and clears the
// sequencer; both registers reset to 1. o_stall stays high from the
// transfer in until the result transfer out; i_stall holds the result.
module modular_exponentiation #(
    parameter int MODULUS_BITS = mex_pkg::DEF_MODULUS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mex_pkg::FIELD_W-1:0]   i_base,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mex_pkg::FIELD_W-1:0]   o_power_mod,
    input  logic                          i_cfg_we,
    input  logic [mex_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mex_pkg::FIELD_W-1:0]   i_cfg_wdata
);
    import mex_pkg::*;

    localparam int MW = MODULUS_BITS;
    localparam int AW = (MW > FIELD_W) ? MW : FIELD_W;

    logic [FIELD_W-1:0] r_exponent;
    logic [MW-1:0]      r_modulus;
    logic [MW-1:0]      w_wdata_m;

    logic          w_mul_start;
    logic          w_mul_done;
    logic [AW-1:0] w_mul_a;
    logic [MW-1:0] w_mul_b;
    logic [MW-1:0] w_mul_m;
    logic [MW-1:0] w_mul_p;

    // keep only the low MODULUS_BITS bits of the modulus
    assign w_wdata_m = MW'({{MW{1'b0}}, i_cfg_wdata});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= FIELD_W'(1);
            r_modulus  <= MW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXPONENT: r_exponent <= i_cfg_wdata;
                REG_MODULUS:  r_modulus  <= w_wdata_m;
                default: ;
            endcase
        end
    end

    mex_seq #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_base      (i_base),
        .i_exponent  (r_exponent),
        .i_modulus   (r_modulus),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_power_mod (o_power_mod),
        .o_mul_start (w_mul_start),
        .o_mul_a     (w_mul_a),
        .o_mul_b     (w_mul_b),
        .o_mul_m     (w_mul_m),
        .i_mul_done  (w_mul_done),
        .i_mul_p     (w_mul_p)
    );

    mex_modmul #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_m     (w_mul_m),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input side not stalled after transfer");

    a_no_in_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    a_mul_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |=> !w_mul_done)
        else $error("multiply finished one cycle after start");

    a_done_not_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> !o_valid)
        else $error("multiply finished while result pending");

endmodule

### tb/modular_exponentiation_test.sv
`timescale 1ns / 100ps

module modular_exponentiation_test;
    import mex_pkg::*;

    localparam int MOD_BITS = DEF_MODULUS_BITS;
    // Indexes past the register list; writes there must not land anywhere
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam int N_DIRECTED = 18;
    localparam int N_PHASES = 24;
    localparam int ITEMS_PER_PHASE = 20;

    typedef struct packed {
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] power_mod;
        logic               known;
    } t_vector;

    // exponent, modulus, base, power_mod, known
    t_vector directed_rows [N_DIRECTED] = '{
        '{24'd1, 24'd1, 24'd5, 24'd0, 1'b1},              // reset values, modulus one
        '{24'd0, 24'd1, FIELD_MAX, 24'd1, 1'b1},          // zero exponent skips reduction
        '{24'd0, 24'd0, 24'd0, 24'd1, 1'b1},
        '{24'd5, 24'd0, 24'd7, 24'd0, 1'b1},              // zero modulus
        '{FIELD_MAX, 24'd0, FIELD_MAX, 24'd0, 1'b1},
        '{24'd1, FIELD_MAX, FIELD_MAX, 24'd0, 1'b1},      // base reduced first
        '{24'd1, FIELD_MAX, 24'hFFFFFE, 24'hFFFFFE, 1'b1},
        '{24'd1, FIELD_MAX, 24'd0, 24'd0, 1'b1},
        '{FIELD_MAX, FIELD_MAX, 24'd1, 24'd1, 1'b1},
        '{FIELD_MAX, FIELD_MAX, 24'd0, 24'd0, 1'b1},
        '{FIELD_MAX, FIELD_MAX, 24'hFFFFFE, 24'd0, 1'b0},
        '{24'd2, FIELD_MAX, 24'hFFFFFE, 24'd0, 1'b0},
        '{24'd17, 24'd3233, 24'd65, 24'd0, 1'b0},         // textbook key pair
        '{24'd2753, 24'd3233, 24'd2790, 24'd0, 1'b0},
        '{24'h800000, 24'd3233, 24'd123, 24'd0, 1'b0},
        '{24'd3, 24'd2, 24'hAAAAAA, 24'd0, 1'b0},
        '{FIELD_MAX, 24'd1, 24'h555555, 24'd0, 1'b1},
        '{24'd0, FIELD_MAX, 24'h123456, 24'd1, 1'b1}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [FIELD_W-1:0]   i_base = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [FIELD_W-1:0]   o_power_mod;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_EXPONENT;
    logic [FIELD_W-1:0]   i_cfg_wdata = '0;

    logic [FIELD_W-1:0] cfg_exponent = 24'd1;
    logic [FIELD_W-1:0] cfg_modulus = 24'd1;
    logic [FIELD_W-1:0] pending_power_mod [$];
    int unsigned        src_idle_pct = 27;
    int unsigned        sink_idle_pct = 72;
    int unsigned        n_errors = 0;

    modular_exponentiation #(
        .MODULUS_BITS(MOD_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_base      (i_base),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_power_mod (o_power_mod),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Square-and-multiply against the shadow registers
    function automatic logic [FIELD_W-1:0] power_mod_of(input logic [FIELD_W-1:0] b);
        logic [63:0]        m;
        logic [63:0]        acc;
        logic [63:0]        sq;
        logic [FIELD_W-1:0] e;
        m = 64'(cfg_modulus) & ((64'd1 << MOD_BITS) - 64'd1);
        e = cfg_exponent;
        if (e == '0)
            return FIELD_W'(1);
        if (m == 64'd0)
            return '0;
        acc = 64'd1 % m;
        sq = 64'(b) % m;
        while (e != '0) begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
        end
        return acc[FIELD_W-1:0];
    endfunction

    // Random value whose top set bit is bit len-1
    function automatic logic [FIELD_W-1:0] random_of_length(input int unsigned len);
        logic [FIELD_W-1:0] v;
        v = FIELD_W'($urandom) & (FIELD_MAX >> (FIELD_W - len));
        v[len-1] = 1'b1;
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] random_base();
        case ($urandom_range(7))
            0: return '0;
            1: return FIELD_MAX;
            2: return (cfg_modulus != '0) ? cfg_modulus - 1'b1 : FIELD_MAX;
            3: return (cfg_modulus != '0) ? FIELD_W'($urandom % cfg_modulus) : '0;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Hold valid low, then wait until every result is back and the block settles
    task automatic drain(input int unsigned settle);
        i_valid <= 1'b0;
        while (pending_power_mod.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        case (idx)
            REG_EXPONENT: cfg_exponent = v;
            REG_MODULUS:  cfg_modulus = v;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [FIELD_W-1:0] e, input logic [FIELD_W-1:0] m,
                               input bit spare);
        drain(4);
        if ($urandom_range(1) == 0) begin
            write_reg(REG_EXPONENT, e);
            write_reg(REG_MODULUS, m);
        end else begin
            write_reg(REG_MODULUS, m);
            write_reg(REG_EXPONENT, e);
        end
        if (spare) begin
            write_reg(REG_SPARE_LO, FIELD_W'($urandom));
            write_reg(REG_SPARE_HI, FIELD_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Valid stays high after a transfer until the next call decides otherwise
    task automatic push_base(input logic [FIELD_W-1:0] b, input bit known,
                             input logic [FIELD_W-1:0] typed);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base <= b;
        do @(posedge i_clk); while (o_stall);
        pending_power_mod.push_back(known ? typed : power_mod_of(b));
    endtask

    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < sink_idle_pct);

    always @(posedge i_clk) begin : check_result
        logic [FIELD_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_power_mod.size() == 0) begin
                $error("power_mod: expected none, actual %h", o_power_mod);
                n_errors++;
            end else begin
                want = pending_power_mod.pop_front();
                if (o_power_mod !== want) begin
                    $error("power_mod: expected %h, actual %h", want, o_power_mod);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int unsigned        k;
        int unsigned        phase;
        t_vector            row;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] m;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            row = directed_rows[k];
            if (row.exponent != cfg_exponent || row.modulus != cfg_modulus)
                load_config(row.exponent, row.modulus, 1'b0);
            push_base(row.base, row.known, row.power_mod);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase == N_PHASES / 3) begin
                src_idle_pct = 72;
                sink_idle_pct = 27;
            end else if (phase == 2 * N_PHASES / 3) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: e = '0;
                1: e = FIELD_MAX;
                2: e = FIELD_W'(1);
                default: e = random_of_length($urandom_range(FIELD_W, 1));
            endcase
            case ($urandom_range(19))
                0: m = '0;
                1: m = FIELD_W'(1);
                2, 3: m = FIELD_MAX;
                4, 5, 6, 7: m = random_of_length($urandom_range(FIELD_W, 1));
                // product of two values below 4096, as an RSA modulus would be
                default: m = FIELD_W'($urandom_range(4095, 2) * $urandom_range(4095, 2));
            endcase
            load_config(e, m, phase == 0 || $urandom_range(5) == 0);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                push_base(random_base(), 1'b0, '0);
        end

        drain(64);
        if (n_errors == 0 && pending_power_mod.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL");
        $finish;
    end

endmodule

### modular_exponentiation.f
rtl/mex_pkg.sv
rtl/mex_modmul.sv
rtl/mex_seq.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
